/* sv/rtst_pkg.sv */
package rtst_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int TAG_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 48;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_BEGIN_OLD = 3'd0;
    localparam logic [2:0] ST_BEGIN_NEW = 3'd1;
    localparam logic [2:0] ST_END_DONE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] region_tag;
        logic [47:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot_index;
        logic [47:0] duration;
        logic [31:0] call_count;
        logic [63:0] total_ticks;
        logic [47:0] min_first;
        logic [47:0] min_second;
        logic [47:0] max_first;
        logic [47:0] max_second;
    } t_out;

    // tag lookup outcome
    typedef struct packed {
        logic hit;
        logic full;
    } t_look;

endpackage

/* sv/rtst_tag_cam.sv */
module rtst_tag_cam #(
    parameter int SLOTS    = rtst_pkg::SLOTS_DEF,
    parameter int TAG_BITS = rtst_pkg::TAG_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [TAG_BITS-1:0]                       i_tag,
    input  logic                                      i_alloc,
    input  logic                                      i_clear,
    output rtst_pkg::t_look                           o_look,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_idx
);
    import rtst_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);

    logic [TAG_BITS-1:0] r_tag [SLOTS];
    logic [FILL_W-1:0]   r_fill;
    logic [SLOTS-1:0]    w_match;
    logic [IDX_W-1:0]    w_enc;

    // valid slots always form a prefix: allocation takes the first free one
    // and the only release is a clear or reset of the whole table
    always_comb begin
        w_enc = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_match[i] = (FILL_W'(i) < r_fill) && (r_tag[i] == i_tag);
            if (w_match[i]) begin
                w_enc = w_enc | IDX_W'(i);
            end
        end
    end

    assign o_look.hit  = |w_match;
    assign o_look.full = (r_fill == FILL_W'(SLOTS));
    assign o_idx       = o_look.hit ? w_enc : r_fill[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
        end else if (i_alloc) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_tag[r_fill[IDX_W-1:0]] <= i_tag;
        end
    end

endmodule

/* sv/region_timing_stats_table.sv */
// Steps: accept (tag lookup and stats memory read), then duration subtract, then
// statistics update, write-back and result. Items do not overlap: a new item is
// taken only in the idle state, after the last one has left its update step;
// a waiting result holds the item in its update step.
// Reset: synchronous active low; empties the table at once (fill count to zero),
// no clearing pass over the memory.
module region_timing_stats_table #(
    parameter int SLOTS     = rtst_pkg::SLOTS_DEF,
    parameter int TAG_BITS  = rtst_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS = rtst_pkg::TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rtst_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rtst_pkg::t_out o_out_item
);
    import rtst_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DUR  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    typedef struct packed {
        logic [TIME_BITS-1:0] start;
        logic [63:0]          sum;
        logic [31:0]          calls;
        logic [TIME_BITS-1:0] lo0;
        logic [TIME_BITS-1:0] lo1;
        logic [TIME_BITS-1:0] hi0;
        logic [TIME_BITS-1:0] hi1;
    } t_entry;

    function automatic logic [47:0] f_to48(logic [TIME_BITS-1:0] v);
        logic [TIME_BITS+47:0] w;
        w = {48'd0, v};
        return w[47:0];
    endfunction

    logic [1:0]           r_state, n_state;
    logic                 w_fire;
    logic [TAG_BITS+15:0] w_tag_ext;
    logic [TAG_BITS-1:0]  w_tag;
    logic [TIME_BITS+47:0] w_ts_ext;
    t_look                w_look;
    logic [IDX_W-1:0]     w_idx;
    logic                 w_alloc;
    logic                 w_clear;

    logic [1:0]           r_op;
    logic [TIME_BITS-1:0] r_ts;
    logic                 r_hit;
    logic                 r_full;
    logic                 r_new;
    logic [IDX_W-1:0]     r_idx;
    t_entry               r_rd;
    logic [TIME_BITS-1:0] r_dur;

    t_entry               r_mem [SLOTS];

    logic                 w_out_free;
    logic                 w_done;
    logic                 w_we;
    t_entry               w_wr;
    t_out                 w_res;
    logic [64:0]          w_sum;
    logic [IDX_W+4:0]     w_idx_ext;

    logic                 r_out_valid;
    t_out                 r_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;

    assign w_tag_ext = {TAG_BITS'(0), i_in_item.region_tag};
    assign w_tag     = w_tag_ext[TAG_BITS-1:0];
    assign w_ts_ext  = {TIME_BITS'(0), i_in_item.timestamp};

    assign w_alloc = w_fire && (i_in_item.operation == OP_BEGIN) && !w_look.hit && !w_look.full;
    assign w_clear = w_fire && (i_in_item.operation == OP_CLEAR);

    rtst_tag_cam #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_alloc (w_alloc),
        .i_clear (w_clear),
        .o_look  (w_look),
        .o_idx   (w_idx)
    );

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_op   <= i_in_item.operation;
            r_ts   <= w_ts_ext[TIME_BITS-1:0];
            r_hit  <= w_look.hit;
            r_full <= w_look.full;
            r_new  <= w_alloc;
            r_idx  <= w_idx;
            r_rd   <= r_mem[w_idx];
        end
        if (r_state == S_DUR) begin
            r_dur <= r_ts - r_rd.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wr;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_done     = (r_state == S_UPD) && w_out_free;
    assign w_sum      = {1'b0, r_rd.sum} + 65'(r_dur);
    assign w_idx_ext  = {5'd0, r_idx};

    always_comb begin
        w_we  = 1'b0;
        w_wr  = r_rd;
        w_res = '0;
        case (r_op)
            OP_BEGIN: begin
                if (r_full && !r_hit) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_we = w_done;
                    w_wr.start = r_ts;
                    if (r_new) begin
                        w_wr.sum   = '0;
                        w_wr.calls = '0;
                        w_wr.lo0   = '1;
                        w_wr.lo1   = '1;
                        w_wr.hi0   = '0;
                        w_wr.hi1   = '0;
                    end
                    w_res.status = r_new ? ST_BEGIN_NEW : ST_BEGIN_OLD;
                end
            end
            OP_END: begin
                if (!r_hit) begin
                    w_res.status = ST_NOT_FOUND;
                end else begin
                    w_we = w_done;
                    w_wr.sum = w_sum[64] ? '1 : w_sum[63:0];
                    if (r_rd.calls != '1) begin
                        w_wr.calls = r_rd.calls + 32'd1;
                    end
                    if (r_dur < r_rd.lo0) begin
                        w_wr.lo1 = r_rd.lo0;
                        w_wr.lo0 = r_dur;
                    end else if (r_dur < r_rd.lo1) begin
                        w_wr.lo1 = r_dur;
                    end
                    if (r_dur > r_rd.hi0) begin
                        w_wr.hi1 = r_rd.hi0;
                        w_wr.hi0 = r_dur;
                    end else if (r_dur > r_rd.hi1) begin
                        w_wr.hi1 = r_dur;
                    end
                    w_res.status   = ST_END_DONE;
                    w_res.duration = f_to48(r_dur);
                end
            end
            OP_CLEAR: begin
                w_res.status = ST_CLEARED;
            end
            default: begin
                w_res.status = ST_NOT_FOUND;
            end
        endcase
        // slot fields only when the item touched a slot
        if (w_res.status == ST_BEGIN_OLD || w_res.status == ST_BEGIN_NEW ||
            w_res.status == ST_END_DONE) begin
            w_res.slot_index  = w_idx_ext[4:0];
            w_res.call_count  = w_wr.calls;
            w_res.total_ticks = w_wr.sum;
            w_res.min_first   = f_to48(w_wr.lo0);
            w_res.min_second  = f_to48(w_wr.lo1);
            w_res.max_first   = f_to48(w_wr.hi0);
            w_res.max_second  = f_to48(w_wr.hi1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    n_state = S_DUR;
                end
            end
            S_DUR: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
